### rtl/bbr_pkg.sv
// box blur package: pixel and line-store types, control structs, register codes
// and constants shared by the front end, the filter pipeline and the top level
// no dependencies
package bbr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_W      = 13;
    localparam int CFG_W         = 13;
    localparam int CFG_WIDTH_W   = 11;
    localparam int DIM_MIN       = 3;
    localparam int HEIGHT_MAX    = 4096;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    // nine 8-bit values sum to at most 2295
    localparam int SUM_W       = 12;
    // floor(s / 9) == (s * 7282) >> 16 for every s below 2296
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } bbr_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } bbr_mode_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // one line-store entry: older line and newer line of the same column
    typedef struct packed {
        rgb_t top;
        rgb_t mid;
    } line_pair_t;

    // per-beat control traveling from the front end into the filter pipeline
    typedef struct packed {
        logic is_pixel;
        logic emit;
        logic use_mean;
        logic frame_end;
        logic top_sel;
    } bbr_ctl_t;

    // filter pipeline status seen by the front end
    typedef struct packed {
        logic ready;
        logic pixel_busy;
    } bbr_fil_stat_t;

endpackage

### rtl/bbr_line_buf.sv
// two-line store: one entry per column holding the older and newer line
// one write port, one read port, registered read data; uses bbr_pkg
module bbr_line_buf import bbr_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output line_pair_t        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_pair_t        wr_data
);

    line_pair_t line_mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bbr_front.sv
// front end: configuration registers, raster position counters and drain state
// decides per input beat what enters the filter and issues the line-store read; uses bbr_pkg
module bbr_front import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_mode,
    input  rgb_t             s_px,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  bbr_fil_stat_t    fil_stat,
    output logic             item_valid,
    output bbr_ctl_t         item_ctl,
    output rgb_t             item_px,
    output logic [COL_W-1:0] item_col,
    output logic             rd_en,
    output logic [COL_W-1:0] rd_addr
);

    localparam int WID_W = COL_W + 1;
    localparam int WIDTH_RST_I = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam logic [WID_W-1:0]    WIDTH_RST  = WID_W'(WIDTH_RST_I);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(HEIGHT_RESET);

    logic [WID_W-1:0]    width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic                draining_reg, draining_next;

    logic [CFG_W-1:0]    wv, wclamp, hv, hclamp;
    logic                is_flush, accept, restart;
    logic [COL_W-1:0]    ic, oc;
    logic [ROW_W-1:0]    ir, orow;
    logic                ic_last, ir_last, oc_last, or_last;
    logic                produce, border, top_sel;

    assign cfg_ready = 1'b1;

    always_comb begin
        wv = CFG_W'(cfg_data[CFG_WIDTH_W-1:0]);
        if (wv < CFG_W'(DIM_MIN)) begin
            wclamp = CFG_W'(DIM_MIN);
        end else if (wv > CFG_W'(MAX_WIDTH)) begin
            wclamp = CFG_W'(MAX_WIDTH);
        end else begin
            wclamp = wv;
        end
        hv = cfg_data;
        if (hv < CFG_W'(DIM_MIN)) begin
            hclamp = CFG_W'(DIM_MIN);
        end else if (hv > CFG_W'(HEIGHT_MAX)) begin
            hclamp = CFG_W'(HEIGHT_MAX);
        end else begin
            hclamp = hv;
        end
    end

    always_comb begin
        is_flush = (bbr_mode_t'(s_mode) == MODE_FLUSH);
        // a flush may read the column the last pixel is still about to write
        s_ready  = fil_stat.ready && !cfg_valid &&
                   !(is_flush && draining_reg && fil_stat.pixel_busy);
        accept   = s_valid && s_ready;
        restart  = draining_reg && !is_flush;

        ic   = restart ? '0 : in_col_reg;
        ir   = restart ? '0 : in_row_reg;
        oc   = restart ? '0 : out_col_reg;
        orow = restart ? '0 : out_row_reg;

        ic_last = (WID_W'(ic) + WID_W'(1)) >= width_reg;
        oc_last = (WID_W'(oc) + WID_W'(1)) >= width_reg;
        ir_last = (HEIGHT_W'(ir) + HEIGHT_W'(1)) >= height_reg;
        or_last = (HEIGHT_W'(orow) + HEIGHT_W'(1)) >= height_reg;
        top_sel = (HEIGHT_W'(orow) + HEIGHT_W'(2)) == height_reg;

        produce = (ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0));
        border  = (orow == '0) || or_last || (oc == '0) || oc_last;
    end

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;

        item_valid         = 1'b0;
        item_ctl.is_pixel  = 1'b1;
        item_ctl.emit      = produce;
        item_ctl.use_mean  = !border;
        item_ctl.frame_end = 1'b0;
        item_ctl.top_sel   = 1'b0;
        item_px            = s_px;
        item_col           = ic;
        rd_en              = 1'b0;
        rd_addr            = ic;

        if (cfg_valid) begin
            unique case (bbr_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = wclamp[WID_W-1:0];
                REG_IMAGE_HEIGHT: height_next = hclamp[HEIGHT_W-1:0];
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            draining_next = 1'b0;
        end else if (accept) begin
            if (!is_flush) begin
                item_valid    = 1'b1;
                rd_en         = 1'b1;
                draining_next = ic_last && ir_last;
                if (ic_last) begin
                    in_col_next = '0;
                    in_row_next = ir_last ? '0 : ir + ROW_W'(1);
                end else begin
                    in_col_next = ic + COL_W'(1);
                    in_row_next = ir;
                end
                out_col_next = oc;
                out_row_next = orow;
                if (produce) begin
                    if (oc_last) begin
                        out_col_next = '0;
                        out_row_next = orow + ROW_W'(1);
                    end else begin
                        out_col_next = oc + COL_W'(1);
                    end
                end
            end else if (draining_reg) begin
                item_valid         = 1'b1;
                rd_en              = 1'b1;
                rd_addr            = oc;
                item_col           = oc;
                item_ctl.is_pixel  = 1'b0;
                item_ctl.emit      = 1'b1;
                item_ctl.use_mean  = 1'b0;
                item_ctl.frame_end = or_last && oc_last;
                item_ctl.top_sel   = top_sel;
                if (or_last && oc_last) begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    draining_next = 1'b0;
                end else if (oc_last) begin
                    out_col_next = '0;
                    out_row_next = orow + ROW_W'(1);
                end else begin
                    out_col_next = oc + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
        end
    end

endmodule

### rtl/bbr_filter.sv
// filter pipeline: line-store read-modify-write, 3x3 window, channel sums,
// divide by nine and the output register; uses bbr_pkg
module bbr_filter import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  bbr_ctl_t         item_ctl,
    input  rgb_t             item_px,
    input  logic [COL_W-1:0] item_col,
    output bbr_fil_stat_t    stat,
    input  line_pair_t       rd_data,
    output logic             wr_en,
    output logic [COL_W-1:0] wr_addr,
    output line_pair_t       wr_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rgb_t             m_px,
    output logic             m_last
);

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] p;
        p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP9);
        return p[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    // stage 1: line-store data arrives
    logic             s1_valid_reg, s1_valid_next;
    bbr_ctl_t         s1_ctl_reg;
    rgb_t             s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    // stage 2: window holds the neighbourhood
    logic             s2_valid_reg, s2_valid_next;
    bbr_ctl_t         s2_ctl_reg;
    rgb_t             s2_flush_px_reg;
    // stage 3: sums ready for the divide
    logic             s3_valid_reg, s3_valid_next;
    logic [SUM_W-1:0] s3_sum_r_reg, s3_sum_g_reg, s3_sum_b_reg;
    rgb_t             s3_pass_reg;
    logic             s3_use_mean_reg;
    logic             s3_last_reg;
    // output register
    logic             out_valid_reg, out_valid_next;
    rgb_t             out_px_reg, out_px_next;
    logic             out_last_reg;

    rgb_t             win_reg [3][3];
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;

    logic out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        s3_adv   = s3_valid_reg && out_free;
        s3_free  = !s3_valid_reg || s3_adv;
        s2_adv   = s2_valid_reg && s3_free;
        s2_free  = !s2_valid_reg || s2_adv;
        s1_adv   = s1_valid_reg && s2_free;
        s1_free  = !s1_valid_reg || s1_adv;

        stat.ready      = s1_free;
        stat.pixel_busy = s1_valid_reg && s1_ctl_reg.is_pixel;

        s1_valid_next  = item_valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? s1_ctl_reg.emit : (s2_adv ? 1'b0 : s2_valid_reg);
        s3_valid_next  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_valid_reg);
        out_valid_next = s3_adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    assign wr_en       = s1_adv && s1_ctl_reg.is_pixel;
    assign wr_addr     = s1_col_reg;
    assign wr_data.top = rd_data.mid;
    assign wr_data.mid = s1_px_reg;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum_r = sum_r + SUM_W'(win_reg[i][j].red);
                sum_g = sum_g + SUM_W'(win_reg[i][j].green);
                sum_b = sum_b + SUM_W'(win_reg[i][j].blue);
            end
        end
    end

    always_comb begin
        if (s3_use_mean_reg) begin
            out_px_next.red   = div9(s3_sum_r_reg);
            out_px_next.green = div9(s3_sum_g_reg);
            out_px_next.blue  = div9(s3_sum_b_reg);
        end else begin
            out_px_next = s3_pass_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_adv && s1_ctl_reg.is_pixel) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= rd_data.top;
            win_reg[1][2] <= rd_data.mid;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            s1_ctl_reg <= item_ctl;
            s1_px_reg  <= item_px;
            s1_col_reg <= item_col;
        end
        if (s1_adv) begin
            s2_ctl_reg      <= s1_ctl_reg;
            s2_flush_px_reg <= s1_ctl_reg.top_sel ? rd_data.top : rd_data.mid;
        end
        if (s2_adv) begin
            s3_sum_r_reg    <= sum_r;
            s3_sum_g_reg    <= sum_g;
            s3_sum_b_reg    <= sum_b;
            s3_pass_reg     <= s2_ctl_reg.is_pixel ? win_reg[1][1] : s2_flush_px_reg;
            s3_use_mean_reg <= s2_ctl_reg.is_pixel && s2_ctl_reg.use_mean;
            s3_last_reg     <= s2_ctl_reg.frame_end;
        end
        if (s3_adv) begin
            out_px_reg   <= out_px_next;
            out_last_reg <= s3_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_px    = out_px_reg;
    assign m_last  = out_last_reg;

endmodule

### rtl/box_blur_3x3_rgb_core.sv
// 3x3 box blur over an RGB raster stream: results pass the line-store, window, sum and
// output registers; one beat per cycle sustained while m_axis_tready is high, one bubble per
// frame where the first flush waits for the last pixel's line-store write; input held off
// while a register write is offered. output runs one row and one pixel behind; flush beats
// drain it. reset clears counters, drain state, window and pipeline, loads 640 x 480
// (width clamped to MAX_WIDTH); line-store contents are kept. uses bbr_pkg
module box_blur_3x3_rgb_core import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic             s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // red_out, green_out, blue_out
    output logic             m_axis_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    bbr_fil_stat_t    fil_stat;
    logic             fe_valid;
    bbr_ctl_t         fe_ctl;
    rgb_t             fe_px;
    logic [COL_W-1:0] fe_col;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    line_pair_t       rd_data;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    line_pair_t       wr_data;
    rgb_t             m_px;

    bbr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_mode     (s_axis_tuser),
        .s_px       (rgb_t'(s_axis_tdata)),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fil_stat   (fil_stat),
        .item_valid (fe_valid),
        .item_ctl   (fe_ctl),
        .item_px    (fe_px),
        .item_col   (fe_col),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    bbr_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bbr_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (fe_valid),
        .item_ctl   (fe_ctl),
        .item_px    (fe_px),
        .item_col   (fe_col),
        .stat       (fil_stat),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_px       (m_px),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = m_px;

    a_issue_into_free_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fe_valid |-> fil_stat.ready)
        else $error("beat issued while filter stage 1 is occupied");

    a_flush_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (fe_valid && !fe_ctl.is_pixel) |-> !fil_stat.pixel_busy)
        else $error("flush read issued ahead of a pending line-store write");

    a_no_same_entry_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("line-store read and write hit the same entry in one cycle");

endmodule

### bench/blur_checker.sv
// blur_checker: watches the pixel, result and register channels of box_blur_3x3_rgb_core,
// predicts each filtered pixel and frame end, and compares every result beat in order
// uses bbr_pkg
module blur_checker import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [23:0]      s_data,
    input  logic             s_user,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [23:0]      m_data,
    input  logic             m_last,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        rgb_t pix;
        logic frame_end;
    } blurred_px_t;

    blurred_px_t expected_px[$];

    rgb_t        older_line [MAX_WIDTH];
    rgb_t        newer_line [MAX_WIDTH];
    rgb_t        win [3][3];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    bit          draining;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string field, input logic [23:0] got,
                                   input logic [23:0] want);
        if (errors < 100)
            $display("%0t blur mismatch on %s: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    function automatic int unsigned used_width();
        if (width_reg < DIM_MIN) return DIM_MIN;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg < DIM_MIN) return DIM_MIN;
        if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        draining = 1'b0;
    endfunction

    function automatic void advance_output(int unsigned w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function automatic rgb_t window_mean();
        int   red_sum;
        int   green_sum;
        int   blue_sum;
        rgb_t mean;
        red_sum   = 0;
        green_sum = 0;
        blue_sum  = 0;
        foreach (win[i, j]) begin
            red_sum   += win[i][j].red;
            green_sum += win[i][j].green;
            blue_sum  += win[i][j].blue;
        end
        mean.red   = 8'(red_sum / 9);
        mean.green = 8'(green_sum / 9);
        mean.blue  = 8'(blue_sum / 9);
        return mean;
    endfunction

    function automatic void blur_predict(bbr_mode_t mode, rgb_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        rgb_t        pre;
        rgb_t        top;
        rgb_t        mid;
        rgb_t        val;
        bit          produce;
        bit          last;
        w = used_width();
        h = used_height();
        if (mode == MODE_FLUSH) begin
            if (!draining) return;
            c    = out_col % MAX_WIDTH;
            val  = (out_row + 2 == h) ? older_line[c] : newer_line[c];
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_px.push_back('{pix: val, frame_end: last});
            if (last) restart_frame();
            else advance_output(w);
            return;
        end

        if (draining) restart_frame();
        c   = in_col % MAX_WIDTH;
        pre = win[1][2];
        top = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = px;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        produce = (in_row >= 2) || (in_row == 1 && c >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
                in_row   = 0;
                draining = 1'b1;
            end
        end
        if (!produce) return;

        // border pixels pass through from the window center
        if (out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w)
            val = (c == 0) ? pre : win[1][1];
        else
            val = window_mean();
        expected_px.push_back('{pix: val, frame_end: 1'b0});
        advance_output(w);
    endfunction

    always @(posedge aclk) begin
        blurred_px_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            restart_frame();
            foreach (win[i, j]) win[i][j] = '0;
            foreach (older_line[i]) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            expected_px.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    report_mismatch("unexpected beat", m_data, '0);
                end else begin
                    want = expected_px.pop_front();
                    if (m_data[7:0] !== want.pix.red)
                        report_mismatch("red", 24'(m_data[7:0]), 24'(want.pix.red));
                    if (m_data[15:8] !== want.pix.green)
                        report_mismatch("green", 24'(m_data[15:8]), 24'(want.pix.green));
                    if (m_data[23:16] !== want.pix.blue)
                        report_mismatch("blue", 24'(m_data[23:16]), 24'(want.pix.blue));
                    if (m_last !== want.frame_end)
                        report_mismatch("frame end", 24'(m_last), 24'(want.frame_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (bbr_reg_t'(cfg_index) == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[CFG_WIDTH_W-1:0];
                else
                    height_reg = cfg_data;
                restart_frame();
            end
            if (s_valid && s_ready)
                blur_predict(bbr_mode_t'(s_user), s_data);
        end
        pending = expected_px.size();
    end

endmodule

### bench/tb_box_blur_3x3_rgb_core.sv
// tb_box_blur_3x3_rgb_core: drives frames, flush beats and geometry writes into the blur core
// with random gaps and stalls; blur_checker predicts and compares. uses bbr_pkg, blur_checker
module tb_box_blur_3x3_rgb_core;
    import bbr_pkg::*;

    typedef enum int {
        FRAME_FULL,
        FRAME_CUT,
        FRAME_SHORT_DRAIN
    } frame_kind_t;

    localparam logic [23:0] CORNER_PX [9] = '{
        24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h000000, 24'h123456, 24'hFFFFFF,
        24'hAA55AA, 24'h55AA55, 24'hFFFFFF
    };

    logic             aclk;
    logic             aresetn;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [23:0]      m_axis_tdata;
    logic             m_axis_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               errors;
    int               pending;

    int frame_w = WIDTH_RESET;
    int frame_h = HEIGHT_RESET;
    int beats;
    bit quiet;
    bit must_restart;

    box_blur_3x3_rgb_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    blur_checker CHK (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .s_user    (s_axis_tuser),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_last    (m_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("[box_blur_3x3_rgb_core] ERROR");
        $finish;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic send_beat(input bbr_mode_t mode, input logic [23:0] data);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold the input until every predicted pixel has come out
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input bbr_reg_t idx, input int val);
        settle(8);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) frame_w = clamp_dim(val, MAX_WIDTH_DEF);
        else frame_h = clamp_dim(val, HEIGHT_MAX);
        must_restart = 1'b0;
    endtask

    task automatic run_frame(input frame_kind_t kind);
        int npix;
        int nflush;
        int pause_at;
        npix = frame_w * frame_h;
        if (kind == FRAME_CUT) npix = $urandom_range(npix / 2, npix - 1);
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, npix - 1) : -1;
        for (int i = 0; i < npix; i++) begin
            if (i == pause_at) settle(0);
            // stray flush mid-frame is dropped by the core
            if (i != 0 && $urandom_range(0, 24) == 0) send_beat(MODE_FLUSH, 24'($urandom));
            send_beat(MODE_PIXEL, 24'($urandom));
            beats++;
        end
        case (kind)
            FRAME_CUT: begin
                nflush = 0;
                must_restart = 1'b1;
            end
            FRAME_SHORT_DRAIN: nflush = $urandom_range(0, frame_w);
            default: nflush = frame_w + 1;
        endcase
        repeat (nflush) begin
            send_beat(MODE_FLUSH, 24'($urandom));
            beats++;
        end
        if (kind == FRAME_FULL && $urandom_range(0, 3) == 0)
            send_beat(MODE_FLUSH, 24'($urandom));
    endtask

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        int          wv;
        int          hv;
        frame_kind_t kind;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = MODE_PIXEL;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        beats         = 0;
        quiet         = 1'b0;
        must_restart  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset geometry: stray flush, then a few pixels cut off by a write
        send_beat(MODE_FLUSH, 24'hFFFFFF);
        send_beat(MODE_PIXEL, 24'h000000);
        send_beat(MODE_PIXEL, 24'hFFFFFF);
        send_beat(MODE_PIXEL, 24'hAAAAAA);
        send_beat(MODE_PIXEL, 24'h555555);

        // smallest frame, one interior pixel, full drain and a late flush
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        foreach (CORNER_PX[i]) send_beat(MODE_PIXEL, CORNER_PX[i]);
        repeat (5) send_beat(MODE_FLUSH, 24'h000000);

        beats = 0;
        while (beats < 900) begin
            if (must_restart || $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 7) == 0) wv = $urandom_range(0, 2);
                else if ($urandom_range(0, 5) == 0) wv = $urandom_range(11, 40);
                else wv = $urandom_range(3, 10);
                hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
                case ($urandom_range(0, 2))
                    0: begin
                        write_reg(REG_IMAGE_WIDTH, wv);
                        write_reg(REG_IMAGE_HEIGHT, hv);
                    end
                    1: write_reg(REG_IMAGE_WIDTH, wv);
                    default: write_reg(REG_IMAGE_HEIGHT, hv);
                endcase
            end
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: kind = FRAME_CUT;
                1: kind = FRAME_SHORT_DRAIN;
                default: kind = FRAME_FULL;
            endcase
            run_frame(kind);
        end

        // out-of-range values clamped: a short start on the widest, tallest geometry,
        // then a frame with both registers below the minimum
        quiet = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        repeat (24) send_beat(MODE_PIXEL, 24'($urandom));
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        run_frame(FRAME_FULL);

        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && pending != 0; n++) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("[box_blur_3x3_rgb_core] OK");
        else
            $display("[box_blur_3x3_rgb_core] ERROR");
        $finish;
    end

endmodule
